/* hw/rtl/dswg_pkg.sv */
// ----------------------------------------------------------------------------
// dswg_pkg
// Shared types and codes for the double-sign watermark guard: item and
// configuration structs, message kinds, modes, verdicts and register indexes.
// ----------------------------------------------------------------------------
package dswg_pkg;

    // field widths
    localparam int unsigned CHAIN_W    = 32;
    localparam int unsigned LEVEL_W    = 32;
    localparam int unsigned TOP_LVL_W  = 30;
    localparam int unsigned ROUND_W    = 32;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned VERDICT_W  = 2;
    localparam int unsigned NUM_ENTRIES = 2;
    localparam int unsigned ENTRY_W    = 1;

    // apb port geometry
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // a level with either top bit set is invalid
    localparam logic [LEVEL_W-1:0] LEVEL_BAD_MASK = 32'hC000_0000;

    // message kinds; unknown codes act as a round block
    localparam logic [KIND_W-1:0] KIND_LEG_BLOCK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEG_ENDORSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RND_BLOCK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RND_PREEND  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RND_ENDORSE = 3'd4;

    // item modes
    localparam logic MODE_CHECK  = 1'b0;
    localparam logic MODE_RECORD = 1'b1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_OK        = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REFUSED   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_LEVEL = 2'd2;

    // register indexes (byte address bit 2)
    localparam logic REG_MAIN_CHAIN     = 1'b0;
    localparam logic REG_MAIN_CHAIN_SET = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [CHAIN_W-1:0] chain;
        logic [LEVEL_W-1:0] level;
        logic [ROUND_W-1:0] round;
        logic [KIND_W-1:0]  kind;
    } item_t;

    typedef struct packed {
        logic [CHAIN_W-1:0] main_chain;
        logic               main_chain_set;
    } cfg_t;

endpackage

/* hw/rtl/dswg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dswg_cfg_regs
// APB register file holding the main chain identifier and its enable bit.
// ----------------------------------------------------------------------------
module dswg_cfg_regs
    import dswg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [CHAIN_W-1:0] main_chain_reg, main_chain_next;
    logic               main_chain_set_reg, main_chain_set_next;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // register write decode
    always_comb begin
        main_chain_next     = main_chain_reg;
        main_chain_set_next = main_chain_set_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_MAIN_CHAIN:     main_chain_next     = pwdata[CHAIN_W-1:0];
                REG_MAIN_CHAIN_SET: main_chain_set_next = pwdata[0];
                default:            main_chain_next     = main_chain_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_chain_reg     <= '0;
            main_chain_set_reg <= 1'b0;
        end else begin
            main_chain_reg     <= main_chain_next;
            main_chain_set_reg <= main_chain_set_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            REG_MAIN_CHAIN:     prdata = main_chain_reg;
            REG_MAIN_CHAIN_SET: prdata = {{(APB_DATA_W-1){1'b0}}, main_chain_set_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.main_chain     = main_chain_reg;
    assign cfg.main_chain_set = main_chain_set_reg;

endmodule

/* hw/rtl/dswg_wm_engine.sv */
// ----------------------------------------------------------------------------
// dswg_wm_engine
// Watermark entries plus the check and record decision for one item.
// ----------------------------------------------------------------------------
module dswg_wm_engine
    import dswg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  item_t                item,
    input  cfg_t                 cfg,
    output logic [VERDICT_W-1:0] verdict
);

    logic [TOP_LVL_W-1:0] top_level_reg       [NUM_ENTRIES];
    logic [ROUND_W-1:0]   top_round_reg       [NUM_ENTRIES];
    logic                 seen_endorse_reg    [NUM_ENTRIES];
    logic                 seen_preendorse_reg [NUM_ENTRIES];
    logic                 migrated_reg        [NUM_ENTRIES];

    logic [TOP_LVL_W-1:0] top_level_next;
    logic [ROUND_W-1:0]   top_round_next;
    logic                 seen_endorse_next;
    logic                 seen_preendorse_next;
    logic                 migrated_next;

    logic [ENTRY_W-1:0]   entry;
    logic [TOP_LVL_W-1:0] lvl, cur_level;
    logic [ROUND_W-1:0]   cur_round;
    logic                 cur_se, cur_sp, cur_mig;
    logic                 level_bad, is_legacy, is_endorse;
    logic                 lvl_gt, lvl_eq, rnd_gt, rnd_eq;
    logic                 check_ok, wr_en, advance;

    // entry select and current watermark
    assign level_bad = |(item.level & LEVEL_BAD_MASK);
    assign entry     = ENTRY_W'(cfg.main_chain_set && (item.chain != cfg.main_chain));
    assign lvl       = item.level[TOP_LVL_W-1:0];
    assign cur_level = top_level_reg[entry];
    assign cur_round = top_round_reg[entry];
    assign cur_se    = seen_endorse_reg[entry];
    assign cur_sp    = seen_preendorse_reg[entry];
    assign cur_mig   = migrated_reg[entry];

    assign lvl_gt = lvl > cur_level;
    assign lvl_eq = lvl == cur_level;
    assign rnd_gt = item.round > cur_round;
    assign rnd_eq = item.round == cur_round;

    assign is_legacy  = (item.kind == KIND_LEG_BLOCK) || (item.kind == KIND_LEG_ENDORSE);
    assign is_endorse = (item.kind == KIND_LEG_ENDORSE) || (item.kind == KIND_RND_ENDORSE);

    // legacy rule or round rule
    always_comb begin
        if (is_legacy) begin
            check_ok = !cur_mig &&
                       (lvl_gt || (lvl_eq && (item.kind == KIND_LEG_ENDORSE) && !cur_se));
        end else begin
            check_ok = lvl_gt ||
                       (lvl_eq && (rnd_gt ||
                        (rnd_eq && (((item.kind == KIND_RND_ENDORSE) && !cur_se) ||
                                    ((item.kind == KIND_RND_PREEND) && !cur_se && !cur_sp)))));
        end
    end

    // verdict
    always_comb begin
        priority if (level_bad)               verdict = VERDICT_BAD_LEVEL;
        else if (item.mode == MODE_RECORD)    verdict = VERDICT_OK;
        else if (check_ok)                    verdict = VERDICT_OK;
        else                                  verdict = VERDICT_REFUSED;
    end

    // record update of the selected entry
    assign wr_en   = fire && (item.mode == MODE_RECORD) && !level_bad;
    assign advance = lvl_gt || rnd_gt;

    always_comb begin
        top_level_next       = lvl_gt ? lvl : cur_level;
        top_round_next       = item.round;
        seen_endorse_next    = (cur_se && !advance) || is_endorse;
        seen_preendorse_next = (cur_sp && !advance) || (item.kind == KIND_RND_PREEND);
        migrated_next        = cur_mig || !is_legacy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                top_level_reg[i]       <= '0;
                top_round_reg[i]       <= '0;
                seen_endorse_reg[i]    <= 1'b0;
                seen_preendorse_reg[i] <= 1'b0;
                migrated_reg[i]        <= 1'b0;
            end
        end else if (wr_en) begin
            top_level_reg[entry]       <= top_level_next;
            top_round_reg[entry]       <= top_round_next;
            seen_endorse_reg[entry]    <= seen_endorse_next;
            seen_preendorse_reg[entry] <= seen_preendorse_next;
            migrated_reg[entry]        <= migrated_next;
        end
    end

`ifndef ASSERT_OFF
    // the stored top level never goes backward
    a_level_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (top_level_reg[0] >= $past(top_level_reg[0])) &&
                           (top_level_reg[1] >= $past(top_level_reg[1])))
        else $error("watermark top level decreased");

    // a check transfer leaves the watermark untouched
    a_check_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.mode == MODE_CHECK) |=>
            $stable(top_round_reg[0]) && $stable(top_round_reg[1]) &&
            $stable(migrated_reg[0]) && $stable(migrated_reg[1]))
        else $error("check transfer changed watermark");

    // an invalid level leaves the watermark untouched
    a_bad_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && level_bad |=>
            $stable(top_level_reg[0]) && $stable(top_level_reg[1]) &&
            $stable(top_round_reg[0]) && $stable(top_round_reg[1]))
        else $error("invalid level changed watermark");
`endif

endmodule

/* hw/rtl/double_sign_watermark_guard.sv */
// ----------------------------------------------------------------------------
// double_sign_watermark_guard
// Path: an input transfer is held in the input register; its verdict then
// moves to the result register, which drives m_tvalid.
// Throughput: one item per cycle while m_tready does not stall; the decision
// and watermark update sit in one combinational step between both registers.
// Reset: aresetn synchronous, active low; clears both watermark entries,
// the configuration registers and all valid flags.
// ----------------------------------------------------------------------------
module double_sign_watermark_guard
    import dswg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,   // chain[31:0], level[63:32], round[95:64]
    input  logic [3:0]            s_tuser,   // mode[0], kind[3:1]

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // verdict[1:0], zero[7:2]

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                 cfg;
    item_t                item_in;
    item_t                item_reg, item_next;
    logic                 in_valid_reg, in_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [VERDICT_W-1:0] verdict;
    logic                 s_xfer, m_xfer, out_free, fire;

    dswg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the input transfer
    assign item_in.mode  = s_tuser[0];
    assign item_in.kind  = s_tuser[3:1];
    assign item_in.chain = s_tdata[31:0];
    assign item_in.level = s_tdata[63:32];
    assign item_in.round = s_tdata[95:64];

    // handshake control
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = out_valid_reg && m_tready;

    dswg_wm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    // input and result stage next values
    always_comb begin
        item_next      = s_xfer ? item_in : item_reg;
        in_valid_next  = s_xfer || (in_valid_reg && !fire);
        verdict_next   = fire ? verdict : verdict_reg;
        out_valid_next = fire || (out_valid_reg && !m_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        verdict_reg <= verdict_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-VERDICT_W){1'b0}}, verdict_reg};

`ifndef ASSERT_OFF
    // input backpressure only when both stages are full and the sink stalls
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    // a processed item always lands in the result register
    a_fire_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item lost");

    // an invalid level always yields the invalid-level verdict
    a_bad_level_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item_reg.level[31:30] != 2'b00) |=> verdict_reg == VERDICT_BAD_LEVEL)
        else $error("invalid level not flagged");
`endif

endmodule
